// ----- design/assert_macros.svh -----
// Assertion macros shared by the cache RTL.
// No dependencies; the files that assert include this header by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
// Expression must never be true.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error(msg);
`else
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// ----- design/sacl_pkg.sv -----
// Shared types and constants for the set-associative cache.
// No dependencies; used by sacl_way_update and set_assoc_cache_lru_fifo.
package sacl_pkg;

  // Default geometry
  localparam int MAX_WAYS_DEF  = 8;
  localparam int MAX_SETS_DEF  = 1024;
  localparam int ADDR_BITS_DEF = 32;

  // Fixed line and index geometry
  localparam int OFFSET_BITS  = 4;
  localparam int MIN_SETS_LOG = 3;
  localparam int MAX_SETS_LOG = 10;

  // Rank field and counters
  localparam int                RANK_W   = 3;
  localparam logic [RANK_W-1:0] RANK_MAX = 3'd7;
  localparam int                CNT_W    = 32;

  // Configuration port
  localparam int              CFG_IDX_W    = 2;
  localparam int              CFG_DATA_W   = 4;
  localparam int              SL_W         = 4;
  localparam int              WL_W         = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_LOG = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SETS_LOG = 2'd2;

  typedef enum logic {
    POL_LRU  = 1'b0,
    POL_FIFO = 1'b1
  } sacl_policy_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL
  } sacl_state_t;

  // Control handed to the way update logic
  typedef struct packed {
    sacl_policy_t    policy;
    logic [WL_W-1:0] ways_log;
  } sacl_ctl_t;

endpackage

// ----- design/sacl_way_update.sv -----
// Tag compare, victim choice and rank update for one set row.
// Depends on sacl_pkg; instantiated by set_assoc_cache_lru_fifo.
module sacl_way_update #(
  parameter int MAX_WAYS = sacl_pkg::MAX_WAYS_DEF,
  parameter int TAG_W    = 25
) (
  input  sacl_pkg::sacl_ctl_t                                ctl,
  input  logic [TAG_W-1:0]                                   tag,
  input  logic [MAX_WAYS-1:0][TAG_W-1:0]                     tag_row,
  input  logic [MAX_WAYS-1:0]                                valid_row,
  input  logic [MAX_WAYS-1:0][sacl_pkg::RANK_W-1:0]          rank_row,
  output logic                                               hit,
  output logic [MAX_WAYS-1:0][TAG_W-1:0]                     tag_row_nxt,
  output logic [MAX_WAYS-1:0]                                valid_row_nxt,
  output logic [MAX_WAYS-1:0][sacl_pkg::RANK_W-1:0]          rank_row_nxt
);

  localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

  logic [MAX_WAYS-1:0]           active;
  logic [MAX_WAYS-1:0]           match;
  logic [WAY_W-1:0]              hit_way;
  logic [WAY_W-1:0]              victim;
  logic [sacl_pkg::RANK_W-1:0]   hit_rank;

  // Flag active ways and tag matches
  always_comb begin
    for (int v = 0; v < MAX_WAYS; v++) begin
      active[v] = (v < (1 << ctl.ways_log));
      match[v]  = active[v] && valid_row[v] && (tag_row[v] == tag);
    end
  end

  // Pick first matching way and the highest-ranked active way
  always_comb begin
    hit_way = '0;
    for (int v = MAX_WAYS - 1; v >= 0; v--) begin
      if (match[v]) begin
        hit_way = WAY_W'(v);
      end
    end
    victim = '0;
    for (int v = 1; v < MAX_WAYS; v++) begin
      if (active[v] && (rank_row[v] > rank_row[victim])) begin
        victim = WAY_W'(v);
      end
    end
  end

  assign hit      = |match;
  assign hit_rank = rank_row[hit_way];

  // Build the new row
  always_comb begin
    tag_row_nxt   = tag_row;
    valid_row_nxt = valid_row;
    rank_row_nxt  = rank_row;
    if (hit) begin
      if (ctl.policy == sacl_pkg::POL_LRU) begin
        for (int v = 0; v < MAX_WAYS; v++) begin
          if (WAY_W'(v) == hit_way) begin
            rank_row_nxt[v] = '0;
          end else if (active[v] && (rank_row[v] < hit_rank)) begin
            rank_row_nxt[v] = rank_row[v] + 1'b1;
          end
        end
      end
    end else begin
      for (int v = 0; v < MAX_WAYS; v++) begin
        if (WAY_W'(v) == victim) begin
          rank_row_nxt[v]  = '0;
          tag_row_nxt[v]   = tag;
          valid_row_nxt[v] = 1'b1;
        end else if (active[v] && (rank_row[v] < sacl_pkg::RANK_MAX)) begin
          rank_row_nxt[v] = rank_row[v] + 1'b1;
        end
      end
    end
  end

endmodule

// ----- design/set_assoc_cache_lru_fifo.sv -----
// Top level of the tag-only set-associative cache with LRU or FIFO replacement.
// Depends on sacl_pkg, sacl_way_update and assert_macros.svh.
//
// Usage:
//   Input channel in_valid/in_stall carries one address word per access.
//   Result channel out_valid/out_stall returns hit, access_count and
//   miss_count for every accepted word, in order.
//   Config channel cfg_valid/cfg_ready/cfg_index/cfg_data writes policy (0),
//   ways_log (1) and sets_log (2); cfg_ready is always high. Write only while
//   no access is in flight.
//   Each access first reads the set row from the tag and metadata memories into
//   the read registers, then compares and writes back that row. The result is
//   loaded into the output register at write-back; no new word is accepted
//   until the previous one has been written back.
//   After reset, and after each write to ways_log or sets_log, a clearing pass
//   of all MAX_SETS rows (1024 by default) resets valid bits and ranks, one set
//   row per cycle; in_stall is high during it. Counters survive config writes.
//   When out_stall holds a result, the evaluation stage waits and in_stall
//   stays high until the output register frees.
module set_assoc_cache_lru_fifo #(
  parameter int MAX_WAYS  = sacl_pkg::MAX_WAYS_DEF,
  parameter int MAX_SETS  = sacl_pkg::MAX_SETS_DEF,
  parameter int ADDR_BITS = sacl_pkg::ADDR_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [ADDR_BITS-1:0]             in_address,
  // Result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_hit,
  output logic [sacl_pkg::CNT_W-1:0]       out_access_count,
  output logic [sacl_pkg::CNT_W-1:0]       out_miss_count,
  // Configuration channel
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sacl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sacl_pkg::CFG_DATA_W-1:0]  cfg_data
);

  `include "assert_macros.svh"

  localparam int LINE_W      = ADDR_BITS - sacl_pkg::OFFSET_BITS;
  localparam int TAG_W       = LINE_W - sacl_pkg::MIN_SETS_LOG;
  localparam int SET_W       = $clog2(MAX_SETS);
  localparam int SETS_LOG_HI = (SET_W < sacl_pkg::MAX_SETS_LOG) ? SET_W
                                                                : sacl_pkg::MAX_SETS_LOG;
  localparam int RANK_W      = sacl_pkg::RANK_W;
  localparam int META_W      = MAX_WAYS * (RANK_W + 1);
  localparam int CNT_W       = sacl_pkg::CNT_W;
  localparam logic [SET_W-1:0] SET_LAST = SET_W'(MAX_SETS - 1);

  // Configuration registers
  sacl_pkg::sacl_policy_t          policy_r;
  logic [sacl_pkg::WL_W-1:0]       ways_log_r;
  logic [sacl_pkg::SL_W-1:0]       sets_log_r;
  logic                            geo_wr;

  // Control state
  sacl_pkg::sacl_state_t           state_r, state_nxt;
  logic [SET_W-1:0]                clr_idx_r, clr_idx_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic                            ev_done;
  logic                            rd_en;

  // Counters and result word
  logic [CNT_W-1:0]                acc_cnt_r, miss_cnt_r;
  logic [CNT_W-1:0]                acc_cnt_nxt, miss_cnt_nxt;
  logic                            out_hit_r;
  logic [CNT_W-1:0]                out_acc_r, out_miss_r;

  // Address split
  logic [sacl_pkg::SL_W-1:0]       sl_eff;
  logic [LINE_W-1:0]               in_line;
  logic [TAG_W-1:0]                in_tag;
  logic [SET_W-1:0]                in_set;
  logic [TAG_W-1:0]                tag_r;
  logic [SET_W-1:0]                set_r;

  // Memories and their ports
  logic [MAX_WAYS-1:0][TAG_W-1:0]  tag_mem [MAX_SETS];
  logic [META_W-1:0]               meta_mem [MAX_SETS];
  logic [MAX_WAYS-1:0][TAG_W-1:0]  tag_rd_r;
  logic [META_W-1:0]               meta_rd_r;
  logic                            tag_we, meta_we;
  logic [SET_W-1:0]                meta_waddr;
  logic [META_W-1:0]               meta_wdata;

  // Row update
  sacl_pkg::sacl_ctl_t                     ctl;
  logic [MAX_WAYS-1:0]                     rd_valid;
  logic [MAX_WAYS-1:0][RANK_W-1:0]         rd_rank;
  logic [MAX_WAYS-1:0][RANK_W-1:0]         rank_init;
  logic                                    upd_hit;
  logic [MAX_WAYS-1:0][TAG_W-1:0]          upd_tag;
  logic [MAX_WAYS-1:0]                     upd_valid;
  logic [MAX_WAYS-1:0][RANK_W-1:0]         upd_rank;

  assign cfg_ready = 1'b1;

  // Take configuration writes; flag geometry changes
  always_comb begin
    geo_wr = 1'b0;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sacl_pkg::CFG_WAYS_LOG: geo_wr = 1'b1;
        sacl_pkg::CFG_SETS_LOG: geo_wr = 1'b1;
        default:                geo_wr = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r   <= sacl_pkg::POL_LRU;
      ways_log_r <= '0;
      sets_log_r <= sacl_pkg::SL_W'(6);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        sacl_pkg::CFG_POLICY:   policy_r   <= sacl_pkg::sacl_policy_t'(cfg_data[0]);
        sacl_pkg::CFG_WAYS_LOG: ways_log_r <= cfg_data[sacl_pkg::WL_W-1:0];
        sacl_pkg::CFG_SETS_LOG: sets_log_r <= cfg_data[sacl_pkg::SL_W-1:0];
        default:                ;
      endcase
    end
  end

  // Clamp set count to the legal range
  always_comb begin
    if (sets_log_r < sacl_pkg::SL_W'(sacl_pkg::MIN_SETS_LOG)) begin
      sl_eff = sacl_pkg::SL_W'(sacl_pkg::MIN_SETS_LOG);
    end else if (sets_log_r > sacl_pkg::SL_W'(SETS_LOG_HI)) begin
      sl_eff = sacl_pkg::SL_W'(SETS_LOG_HI);
    end else begin
      sl_eff = sets_log_r;
    end
  end

  // Split the address word into set index and tag
  assign in_line = in_address[ADDR_BITS-1:sacl_pkg::OFFSET_BITS];
  assign in_tag  = TAG_W'(in_line >> sl_eff);
  assign in_set  = in_line[SET_W-1:0] & ~({SET_W{1'b1}} << sl_eff);

  assign in_stall = (state_r != sacl_pkg::ST_IDLE);
  assign rd_en    = in_valid && !in_stall;

  // Identity ranks for a cleared row
  always_comb begin
    for (int v = 0; v < MAX_WAYS; v++) begin
      rank_init[v] = RANK_W'(v);
    end
  end

  // Sequence clear, accept and evaluate
  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    ev_done       = 1'b0;
    tag_we        = 1'b0;
    meta_we       = 1'b0;
    meta_waddr    = set_r;
    meta_wdata    = {upd_valid, upd_rank};
    case (state_r)
      sacl_pkg::ST_CLEAR: begin
        meta_we    = 1'b1;
        meta_waddr = clr_idx_r;
        meta_wdata = {{MAX_WAYS{1'b0}}, rank_init};
        if (clr_idx_r == SET_LAST) begin
          state_nxt = sacl_pkg::ST_IDLE;
        end else begin
          clr_idx_nxt = clr_idx_r + 1'b1;
        end
      end
      sacl_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = sacl_pkg::ST_EVAL;
        end
      end
      sacl_pkg::ST_EVAL: begin
        if (!out_valid_r || !out_stall) begin
          ev_done   = 1'b1;
          meta_we   = 1'b1;
          tag_we    = !upd_hit;
          state_nxt = sacl_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sacl_pkg::ST_CLEAR;
      end
    endcase
    if (geo_wr) begin
      state_nxt   = sacl_pkg::ST_CLEAR;
      clr_idx_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= sacl_pkg::ST_CLEAR;
      clr_idx_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_idx_r <= clr_idx_nxt;
    end
  end

  // Latch set and tag of the accepted word
  always_ff @(posedge clk) begin
    if (rd_en) begin
      set_r <= in_set;
      tag_r <= in_tag;
    end
  end

  // Tag row memory
  always_ff @(posedge clk) begin
    if (tag_we) begin
      tag_mem[set_r] <= upd_tag;
    end
    if (rd_en) begin
      tag_rd_r <= tag_mem[in_set];
    end
  end

  // Valid and rank row memory
  always_ff @(posedge clk) begin
    if (meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
    if (rd_en) begin
      meta_rd_r <= meta_mem[in_set];
    end
  end

  assign rd_valid = meta_rd_r[META_W-1 -: MAX_WAYS];
  assign rd_rank  = meta_rd_r[MAX_WAYS*RANK_W-1:0];

  assign ctl.policy   = policy_r;
  assign ctl.ways_log = ways_log_r;

  sacl_way_update #(
    .MAX_WAYS (MAX_WAYS),
    .TAG_W    (TAG_W)
  ) u_way_update (
    .ctl           (ctl),
    .tag           (tag_r),
    .tag_row       (tag_rd_r),
    .valid_row     (rd_valid),
    .rank_row      (rd_rank),
    .hit           (upd_hit),
    .tag_row_nxt   (upd_tag),
    .valid_row_nxt (upd_valid),
    .rank_row_nxt  (upd_rank)
  );

  // Advance counters and load the result word
  assign acc_cnt_nxt  = acc_cnt_r + 1'b1;
  assign miss_cnt_nxt = miss_cnt_r + CNT_W'(!upd_hit);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (ev_done) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_cnt_r   <= '0;
      miss_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (ev_done) begin
        acc_cnt_r  <= acc_cnt_nxt;
        miss_cnt_r <= miss_cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ev_done) begin
      out_hit_r  <= upd_hit;
      out_acc_r  <= acc_cnt_nxt;
      out_miss_r <= miss_cnt_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_hit          = out_hit_r;
  assign out_access_count = out_acc_r;
  assign out_miss_count   = out_miss_r;

  // Checks
  `ASSERT_NEXT(a_accept_to_eval, clk, rst_n, rd_en && !geo_wr, state_r == sacl_pkg::ST_EVAL, "accepted word did not enter evaluation")
  `ASSERT_NEXT(a_acc_step, clk, rst_n, ev_done, acc_cnt_r == CNT_W'($past(acc_cnt_r) + 1'b1), "access count did not step by one")
  `ASSERT_NEXT(a_hit_keeps_miss, clk, rst_n, ev_done && upd_hit, $stable(miss_cnt_r), "miss count moved on a hit")
  `ASSERT_NEVER(a_no_rd_wr_overlap, clk, rst_n, rd_en && meta_we, "row read and write-back overlap")

endmodule

// ----- bench/set_assoc_cache_lru_fifo_test.sv -----
// Self-checking bench for set_assoc_cache_lru_fifo: drives address words with random
// idling, predicts hit and counters in a scoreboard class, and checks every result word.
// Depends on sacl_pkg and the set_assoc_cache_lru_fifo RTL.
module set_assoc_cache_lru_fifo_test;

  localparam int                             HALF_PERIOD = 10;
  localparam int                             RESET_CYCLES = 12;
  localparam int                             POOL_DEPTH = 12;
  localparam int                             HOLD_OFF_CYCLES = 400;
  localparam logic [sacl_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct {
    bit        hit;
    bit [31:0] access_count;
    bit [31:0] miss_count;
  } cache_result_t;

  // Tag-store shadow of the cache plus the queue of predicted result words
  class cache_scoreboard;
    sacl_pkg::sacl_policy_t policy;
    bit [1:0]               ways_log;
    bit [3:0]               sets_log;
    bit [27:0]              tag_mem [8192];
    bit                     valid_mem [8192];
    bit [2:0]               rank_mem [8192];
    bit [31:0]              access_cnt;
    bit [31:0]              miss_cnt;
    cache_result_t          expected_results [$];
    int                     errors;

    function new();
      policy     = sacl_pkg::POL_LRU;
      ways_log   = 2'd0;
      sets_log   = 4'd6;
      access_cnt = '0;
      miss_cnt   = '0;
      errors     = 0;
      clear_lines();
    endfunction

    // Drop all valid bits and put every rank back to its way index
    function void clear_lines();
      for (int i = 0; i < 8192; i++) begin
        valid_mem[i] = 1'b0;
        rank_mem[i]  = 3'(i % 8);
      end
    endfunction

    function void write_reg(bit [sacl_pkg::CFG_IDX_W-1:0] idx,
                            bit [sacl_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        sacl_pkg::CFG_POLICY: begin
          policy = sacl_pkg::sacl_policy_t'(data[0]);
        end
        sacl_pkg::CFG_WAYS_LOG: begin
          ways_log = data[1:0];
          clear_lines();
        end
        sacl_pkg::CFG_SETS_LOG: begin
          sets_log = data;
          clear_lines();
        end
        default: begin
        end
      endcase
    endfunction

    // Clamp the set count into the legal index range
    function int unsigned eff_sets_log();
      if (sets_log < sacl_pkg::MIN_SETS_LOG) return sacl_pkg::MIN_SETS_LOG;
      if (sets_log > sacl_pkg::MAX_SETS_LOG) return sacl_pkg::MAX_SETS_LOG;
      return sets_log;
    endfunction

    function void note_access(bit [31:0] addr);
      int unsigned   sl;
      int unsigned   ways;
      int unsigned   base;
      int            hit_way;
      int unsigned   victim;
      bit [27:0]     line;
      bit [27:0]     tag;
      bit [2:0]      r;
      cache_result_t exp_word;
      sl      = eff_sets_log();
      ways    = 1 << ways_log;
      line    = addr[31:sacl_pkg::OFFSET_BITS];
      base    = (line & ((28'd1 << sl) - 1)) * 8;
      tag     = line >> sl;
      hit_way = -1;
      access_cnt++;
      for (int w = 0; w < ways; w++) begin
        if (hit_way < 0 && valid_mem[base + w] && tag_mem[base + w] == tag) hit_way = w;
      end
      if (hit_way >= 0) begin
        // LRU promotes the hit way; FIFO leaves the order alone
        if (policy == sacl_pkg::POL_LRU) begin
          r = rank_mem[base + hit_way];
          for (int v = 0; v < ways; v++) begin
            if (rank_mem[base + v] < r) rank_mem[base + v]++;
          end
          rank_mem[base + hit_way] = 3'd0;
        end
      end else begin
        // Evict the last-ranked way and insert the new tag as most recent
        victim = 0;
        for (int v = 1; v < ways; v++) begin
          if (rank_mem[base + v] > rank_mem[base + victim]) victim = v;
        end
        for (int v = 0; v < ways; v++) begin
          if (v != victim && rank_mem[base + v] < sacl_pkg::RANK_MAX) rank_mem[base + v]++;
        end
        rank_mem[base + victim]  = 3'd0;
        tag_mem[base + victim]   = tag;
        valid_mem[base + victim] = 1'b1;
        miss_cnt++;
      end
      exp_word.hit          = (hit_way >= 0);
      exp_word.access_count = access_cnt;
      exp_word.miss_count   = miss_cnt;
      expected_results      = {expected_results, exp_word};
    endfunction

    function void check_result(bit hit, bit [31:0] acc, bit [31:0] miss);
      cache_result_t exp_word;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result word, hit %0d access %0d miss %0d",
                 $time, hit, acc, miss);
        errors++;
        return;
      end
      exp_word = expected_results.pop_front();
      if (hit !== exp_word.hit) begin
        $display("%0t: hit mismatch, expected %0d, actual %0d", $time, exp_word.hit, hit);
        errors++;
      end
      if (acc !== exp_word.access_count) begin
        $display("%0t: access_count mismatch, expected %0d, actual %0d",
                 $time, exp_word.access_count, acc);
        errors++;
      end
      if (miss !== exp_word.miss_count) begin
        $display("%0t: miss_count mismatch, expected %0d, actual %0d",
                 $time, exp_word.miss_count, miss);
        errors++;
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_stall;
  logic [31:0]                     in_address;
  logic                            out_valid;
  logic                            out_stall;
  logic                            out_hit;
  logic [sacl_pkg::CNT_W-1:0]      out_access_count;
  logic [sacl_pkg::CNT_W-1:0]      out_miss_count;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [sacl_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [sacl_pkg::CFG_DATA_W-1:0] cfg_data;

  cache_scoreboard board = new();
  bit [31:0]       tag_pool [POOL_DEPTH];
  int              pool_span = POOL_DEPTH;
  int              tx_idle_pct = 0;
  int              rx_stall_pct = 0;
  logic            hold_rx;

  set_assoc_cache_lru_fifo u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_address       (in_address),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_hit          (out_hit),
    .out_access_count (out_access_count),
    .out_miss_count   (out_miss_count),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk        = 1'b0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_address = '0;
    out_stall  = 1'b0;
    hold_rx    = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
  end

  always #HALF_PERIOD clk = ~clk;

  // Check each result word taken at this edge, then pick the next stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      board.check_result(out_hit, out_access_count, out_miss_count);
    end
    out_stall <= hold_rx || ($urandom_range(99) < rx_stall_pct);
  end

  // Offer one address word, idling first at random; hold it until taken
  task automatic send_word(input bit [31:0] addr);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_address <= addr;
    do @(posedge clk); while (in_stall);
    board.note_access(addr);
  endtask

  // Stop offering and wait until every predicted word has come back
  task automatic flush_results();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  // Write one register once the block is drained and not clearing
  task automatic program_reg(input logic [sacl_pkg::CFG_IDX_W-1:0] idx,
                             input logic [sacl_pkg::CFG_DATA_W-1:0] data);
    in_valid <= 1'b0;
    do @(posedge clk); while (in_stall || board.pending() != 0);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    board.write_reg(idx, data);
    cfg_valid <= 1'b0;
  endtask

  // Mostly reuse a few tags in the low sets so hits and evictions happen
  function automatic bit [31:0] pick_address();
    int unsigned sl;
    bit [31:0]   a;
    sl = board.eff_sets_log();
    if ($urandom_range(99) < 25) return $urandom;
    a = tag_pool[$urandom_range(pool_span - 1)] << (sl + sacl_pkg::OFFSET_BITS);
    a = a | ($urandom_range(3) << sacl_pkg::OFFSET_BITS) | $urandom_range(15);
    return a;
  endfunction

  task automatic run_phase(input sacl_pkg::sacl_policy_t pol, input bit [1:0] wl,
                           input bit [3:0] sl,
                           input int n, input int tx_pct, input int rx_pct,
                           input bit hold_off, input bit mid_pause);
    bit [3:0] junk;
    junk = 4'($urandom);
    program_reg(sacl_pkg::CFG_POLICY, {junk[3:1], pol});
    program_reg(sacl_pkg::CFG_WAYS_LOG, {junk[3:2], wl});
    program_reg(sacl_pkg::CFG_SETS_LOG, sl);
    for (int k = 0; k < POOL_DEPTH; k++) tag_pool[k] = $urandom;
    pool_span    = ((1 << wl) + 3 > POOL_DEPTH) ? POOL_DEPTH : (1 << wl) + 3;
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    // Hold the result side off long enough to back the block up
    if (hold_off) begin
      fork
        begin
          hold_rx <= 1'b1;
          repeat (HOLD_OFF_CYCLES) @(posedge clk);
          hold_rx <= 1'b0;
        end
      join_none
    end
    for (int i = 0; i < n; i++) begin
      if (mid_pause && i == n / 2) flush_results();
      send_word(pick_address());
    end
    flush_results();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Reset geometry: one way, 64 sets; a cold zero tag must miss
    send_word(32'h0000_0000);
    send_word(32'h0000_000F);
    send_word(32'hFFFF_FFFF);
    send_word(32'hFFFF_FFF0);
    send_word(32'h0000_0400);
    send_word(32'h0000_0000);

    // Eight ways, oversized set count: fill set 0, then exercise LRU victims
    program_reg(sacl_pkg::CFG_WAYS_LOG, 4'd3);
    program_reg(sacl_pkg::CFG_SETS_LOG, 4'd15);
    for (int t = 0; t < 8; t++) send_word(32'(t) << 14);
    send_word(32'h0000_0000);
    send_word(32'h0002_0000);
    send_word(32'h0000_0000);
    send_word(32'h0000_4000);

    // Switch to FIFO with contents kept: hits must not reorder
    program_reg(sacl_pkg::CFG_POLICY, 4'd1);
    send_word(32'h0000_8000);
    send_word(32'h0002_4000);
    send_word(32'h0000_8000);

    // Undersized set count and a write to the spare index
    program_reg(sacl_pkg::CFG_SETS_LOG, 4'd0);
    program_reg(CFG_SPARE, 4'hF);
    send_word(32'h0000_0070);
    send_word(32'h0000_0080);
    flush_results();

    // Random phases across policies, geometries and idling
    run_phase(sacl_pkg::POL_LRU,  2'd0, 4'd3,  100, 0,  0,  1'b0, 1'b0);
    run_phase(sacl_pkg::POL_FIFO, 2'd3, 4'd3,  100, 66, 0,  1'b0, 1'b0);
    run_phase(sacl_pkg::POL_LRU,  2'd3, 4'd10, 100, 0,  66, 1'b1, 1'b0);
    run_phase(sacl_pkg::POL_FIFO, 2'd1, 4'd15, 100, 23, 23, 1'b0, 1'b0);
    run_phase(sacl_pkg::POL_LRU,  2'd2, 4'd0,  100, 0,  0,  1'b0, 1'b1);
    run_phase(sacl_pkg::POL_FIFO, 2'd3, 4'd4,  100, 23, 23, 1'b0, 1'b0);

    // Let any stray word show up before the verdict
    repeat (20) @(posedge clk);
    if (board.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #(2 * HALF_PERIOD * 400000);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
